>>> rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Opcode and status codes, field widths, the cell control struct and the
// default sizing handed to the top level.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int DEPTH_DEF       = 128;
  localparam int ENTRY_WIDTH_DEF = 32;
  // cells per first-level group of the read-out tree
  localparam int GROUP           = 16;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_AT    = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_AT    = 3'd4,
    OP_REM_BACK  = 3'd5,
    OP_READ_AT   = 3'd6,
    OP_NOP       = 3'd7
  } pal_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } pal_status_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_UP   = 2'd1,
    KIND_DOWN = 2'd2,
    KIND_READ = 2'd3
  } pal_kind_t;

  // update command broadcast along the cell row
  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } pal_ctrl_t;

endpackage

>>> rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell: one storage cell of the list row
// Holds the entry at a fixed position; takes the left neighbor on an insert
// above the target, the new word at the target, and the right neighbor on a
// remove at or above the target.
// ----------------------------------------------------------------------------
module pal_cell import pal_pkg::*; #(
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
  parameter int IDX_W       = 7,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  pal_ctrl_t              ctrl,
  input  logic [IDX_W-1:0]       tgt,
  input  logic [ENTRY_WIDTH-1:0] word,
  input  logic [ENTRY_WIDTH-1:0] left,
  input  logic [ENTRY_WIDTH-1:0] right,
  output logic [ENTRY_WIDTH-1:0] data,
  output logic [ENTRY_WIDTH-1:0] hit
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [ENTRY_WIDTH-1:0] data_r;
  logic [ENTRY_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_up) begin
      if (MY_IDX == tgt) begin
        data_nxt = word;
      end else if (MY_IDX > tgt) begin
        data_nxt = left;
      end
    end else if (ctrl.shift_down && (MY_IDX >= tgt)) begin
      data_nxt = right;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = (MY_IDX == tgt) ? data_r : '0;

endmodule

>>> rtl/pal_gather.sv
// ----------------------------------------------------------------------------
// pal_gather: read-out tree over the cell row
// ORs the one selected cell value in registered groups, then across groups.
// ----------------------------------------------------------------------------
module pal_gather import pal_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic [ENTRY_WIDTH-1:0] hit [DEPTH],
  output logic [ENTRY_WIDTH-1:0] sel
);

  localparam int NGRP = (DEPTH + GROUP - 1) / GROUP;

  logic [ENTRY_WIDTH-1:0] grp_r   [NGRP];
  logic [ENTRY_WIDTH-1:0] grp_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | hit[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  always_comb begin
    sel = '0;
    for (int g = 0; g < NGRP; g++) begin
      sel = sel | grp_r[g];
    end
  end

endmodule

>>> rtl/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list: ordered list with insert/remove/read at a position
// Steps: the input transfer loads the command, GATHER fills the two-level
//   read-out tree's group registers, FINISH commits the row and loads the
//   result; a stalled result holds FINISH. One item at a time.
// Reset: rst_n synchronous, active low; clears the count, the sequencer and
//   the output valid. Cell contents stay undefined until written.
// ----------------------------------------------------------------------------
module positional_array_list import pal_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // fields from bit 0: opcode[2:0], position[10:3], entry_in[42:11], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // fields from bit 0: entry_out[31:0], status[33:32], count[41:34], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // sequencer: IDLE takes an item, GATHER fills the group registers,
  // FINISH commits the row and loads the result register
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GATHER = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // unpack the input transfer
  pal_op_t          in_op;
  logic [POS_W-1:0] in_position;
  logic [DATA_W-1:0] in_entry;
  logic [63:0]      in_wide;
  logic [ENTRY_WIDTH-1:0] in_word;

  assign in_op       = pal_op_t'(in_tdata[OPCODE_W-1:0]);
  assign in_position = in_tdata[OPCODE_W +: POS_W];
  assign in_entry    = in_tdata[OPCODE_W+POS_W +: DATA_W];
  assign in_wide     = {32'b0, in_entry};
  assign in_word     = in_wide[ENTRY_WIDTH-1:0];

  logic in_xfer;
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // count and captured command
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  pal_kind_t              kind_r;
  pal_status_t            st_r;
  logic [IDX_W-1:0]       tgt_r;
  logic [ENTRY_WIDTH-1:0] word_r;

  // decode against the count at the input transfer
  pal_kind_t        dec_kind;
  pal_status_t      dec_st;
  logic [CMP_W-1:0] pos_cmp, cnt_cmp, dec_tgt;

  always_comb begin
    pos_cmp  = CMP_W'(in_position);
    cnt_cmp  = CMP_W'(cnt_r);
    dec_tgt  = '0;
    dec_kind = KIND_NONE;
    dec_st   = ST_OK;
    case (in_op)
      OP_INS_FRONT, OP_INS_AT, OP_INS_BACK: begin
        if (in_op == OP_INS_FRONT) begin
          dec_tgt = '0;
        end else if (in_op == OP_INS_BACK) begin
          dec_tgt = cnt_cmp;
        end else begin
          dec_tgt = pos_cmp;
        end
        // fullness wins over the position check
        if (cnt_r == CNT_FULL) begin
          dec_st = ST_FULL;
        end else if (dec_tgt > cnt_cmp) begin
          dec_st = ST_RANGE;
        end else begin
          dec_kind = KIND_UP;
        end
      end
      OP_REM_FRONT, OP_REM_AT, OP_REM_BACK, OP_READ_AT: begin
        if (in_op == OP_REM_FRONT) begin
          dec_tgt = '0;
        end else if (in_op == OP_REM_BACK) begin
          dec_tgt = cnt_cmp - CMP_W'(1);
        end else begin
          dec_tgt = pos_cmp;
        end
        // emptiness wins over the position check
        if (cnt_r == '0) begin
          dec_st = ST_EMPTY;
        end else if (dec_tgt >= cnt_cmp) begin
          dec_st = ST_RANGE;
        end else if (in_op == OP_READ_AT) begin
          dec_kind = KIND_READ;
        end else begin
          dec_kind = KIND_DOWN;
        end
      end
      default: begin
        // unused opcode: no operation, status ok
        dec_kind = KIND_NONE;
      end
    endcase
  end

  // finish step advances only when the result register is free
  logic fin_go;
  assign fin_go = (state_r == S_FINISH) && (!out_tvalid || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_GATHER;
      S_GATHER: state_nxt = S_FINISH;
      S_FINISH: if (fin_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (fin_go) begin
      if (kind_r == KIND_UP) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (kind_r == KIND_DOWN) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      kind_r  <= KIND_NONE;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (in_xfer) begin
        kind_r <= dec_kind;
      end
    end
  end

  // command payload: hold from the input transfer until the finish step
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      st_r   <= dec_st;
      tgt_r  <= dec_tgt[IDX_W-1:0];
      word_r <= in_word;
    end
  end

  // cell row: each cell sees its two neighbors; ends: new word, own value
  pal_ctrl_t              ctrl;
  logic [ENTRY_WIDTH-1:0] cell_q   [DEPTH];
  logic [ENTRY_WIDTH-1:0] cell_hit [DEPTH];

  assign ctrl.shift_up   = fin_go && (kind_r == KIND_UP);
  assign ctrl.shift_down = fin_go && (kind_r == KIND_DOWN);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = word_r;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    pal_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .IDX_W       (IDX_W),
      .INDEX       (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .tgt   (tgt_r),
      .word  (word_r),
      .left  (left_d),
      .right (right_d),
      .data  (cell_q[i]),
      .hit   (cell_hit[i])
    );
  end

  // read-out of the target cell, settled by the finish step
  logic [ENTRY_WIDTH-1:0] sel;

  pal_gather #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_gather (
    .clk (clk),
    .hit (cell_hit),
    .sel (sel)
  );

  // result register: the removed or read word, zero for everything else
  logic [63:0]       got_wide;
  logic [DATA_W-1:0] got;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_entry_r;
  pal_status_t       out_st_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic [CMP_W+COUNT_W-1:0] cnt_ext;

  assign got_wide = 64'(sel);
  assign got      = ((kind_r == KIND_DOWN) || (kind_r == KIND_READ)) ?
                    got_wide[DATA_W-1:0] : '0;
  assign cnt_ext  = (CMP_W+COUNT_W)'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_entry_r <= got;
      out_st_r    <= st_r;
      out_cnt_r   <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DATA_W-STATUS_W-COUNT_W){1'b0}},
                       out_cnt_r, out_st_r, out_entry_r};

endmodule

>>> rtl/pal_checker.sv
// ----------------------------------------------------------------------------
// pal_checker: port-level checks of the positional array list
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module pal_checker import pal_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

  logic [DATA_W-1:0]   o_entry;
  logic [STATUS_W-1:0] o_st;
  logic [COUNT_W-1:0]  o_cnt;

  assign o_entry = out_tdata[DATA_W-1:0];
  assign o_st    = out_tdata[DATA_W +: STATUS_W];
  assign o_cnt   = out_tdata[DATA_W+STATUS_W +: COUNT_W];

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // a full report carries the full count and no word
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o_st == ST_FULL) |-> (o_cnt == FULL_CNT) && (o_entry == '0))
    else $error("full status with wrong count or word");

  // an empty report carries a zero count and no word
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o_st == ST_EMPTY) |-> (o_cnt == '0) && (o_entry == '0))
    else $error("empty status with wrong count or word");

  // an out-of-range report returns no word
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o_st == ST_RANGE) |-> (o_entry == '0))
    else $error("range status with a word");

endmodule

bind positional_array_list pal_checker #(.DEPTH(DEPTH)) u_pal_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional array list
// Drives list operations over the input stream and checks every result
// transfer against a queue-based model of the list or a typed row's result.
// A short table of directed rows opens the run: empty, range, unused opcode, build, read, drain.
// Random phases follow that grow, fill, mix and drain the list.
// ----------------------------------------------------------------------------
module tb_top;
  import pal_pkg::*;

  localparam int LIST_DEPTH    = DEPTH_DEF;
  localparam int PHASE_ITEMS   = 150;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 21;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {
    PH_GROW,
    PH_MIX,
    PH_SHRINK,
    PH_FILL
  } phase_kind_t;

  // one result as the block reports it
  typedef struct {
    logic [DATA_W-1:0]  entry;
    pal_status_t        status;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  // one directed row: operation plus an optional hand-written result
  typedef struct {
    pal_op_t            op;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  word;
    bit                 typed;
    list_result_t       want;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  // model of the list contents, index 0 is the front
  logic [DATA_W-1:0] held_entries[$];
  // results still owed by the block, oldest first
  list_result_t      pending_results[$];
  stim_row_t         dir_rows[$];

  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit          no_idle = 1'b0;

  positional_array_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one operation to the model and return the result it must produce.
  // Fullness and emptiness are checked before the position.
  function automatic list_result_t apply_list_op(pal_op_t op, logic [POS_W-1:0] pos,
                                                 logic [DATA_W-1:0] word);
    list_result_t res;
    int           n;
    int           p;
    res.entry  = '0;
    res.status = ST_OK;
    n = held_entries.size();
    p = int'(pos);
    case (op)
      OP_INS_FRONT, OP_INS_AT, OP_INS_BACK: begin
        if (op == OP_INS_FRONT) p = 0;
        else if (op == OP_INS_BACK) p = n;
        if (n >= LIST_DEPTH) res.status = ST_FULL;
        else if (p > n) res.status = ST_RANGE;
        else held_entries.insert(p, word);
      end
      OP_REM_FRONT, OP_REM_AT, OP_REM_BACK, OP_READ_AT: begin
        if (op == OP_REM_FRONT) p = 0;
        else if (op == OP_REM_BACK) p = n - 1;
        if (n == 0) res.status = ST_EMPTY;
        else if (p >= n) res.status = ST_RANGE;
        else begin
          res.entry = held_entries[p];
          if (op != OP_READ_AT) held_entries.delete(p);
        end
      end
      default: ;  // unused opcode leaves the list alone
    endcase
    res.count = COUNT_W'(held_entries.size());
    return res;
  endfunction

  function automatic void add_row(pal_op_t op, logic [POS_W-1:0] pos,
                                  logic [DATA_W-1:0] word, bit typed,
                                  logic [DATA_W-1:0] entry, pal_status_t status,
                                  logic [COUNT_W-1:0] count);
    stim_row_t row;
    row.op          = op;
    row.pos         = pos;
    row.word        = word;
    row.typed       = typed;
    row.want.entry  = entry;
    row.want.status = status;
    row.want.count  = count;
    dir_rows.push_back(row);
  endfunction

  // Pick an opcode for the phase; rolls below 2 give a no-op, the rest below ins_pct an insert.
  function automatic pal_op_t pick_op(phase_kind_t kind);
    int ins_pct;
    int roll;
    case (kind)
      PH_GROW:   ins_pct = 75;
      PH_SHRINK: ins_pct = 25;
      PH_FILL:   ins_pct = 95;
      default:   ins_pct = 50;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 2) return OP_NOP;
    if (roll < ins_pct) return pal_op_t'($urandom_range(OP_INS_FRONT, OP_INS_BACK));
    return pal_op_t'($urandom_range(OP_REM_FRONT, OP_READ_AT));
  endfunction

  // Mostly a legal position for the current fill; now and then any 8-bit value.
  function automatic logic [POS_W-1:0] pick_pos(pal_op_t op);
    int n;
    n = held_entries.size();
    if ($urandom_range(0, 99) < 15) return POS_W'($urandom_range(0, 255));
    if (op inside {OP_INS_FRONT, OP_INS_AT, OP_INS_BACK}) return POS_W'($urandom_range(0, n));
    if (n == 0) return '0;
    return POS_W'($urandom_range(0, n - 1));
  endfunction

  // Offer one item, hold it until the transfer, then book its result.
  // Called at a rising edge; leaves at the edge of the transfer.
  task automatic send_list_op(pal_op_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] word,
                              bit typed, list_result_t want);
    list_result_t model_res;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {{(IN_TDATA_W - OPCODE_W - POS_W - DATA_W){1'b0}}, word, pos, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    // the model always advances; typed rows replace its answer with their own
    model_res = apply_list_op(op, pos, word);
    pending_results.push_back(typed ? want : model_res);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result sink: stall at random except during the quiet stretch.
  always @(posedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result transfer with the oldest booked result.
  always @(posedge clk) begin
    list_result_t want;
    logic [DATA_W-1:0]   got_entry;
    logic [STATUS_W-1:0] got_status;
    logic [COUNT_W-1:0]  got_count;
    if (rst_n && out_tvalid && out_tready) begin
      got_entry  = out_tdata[DATA_W-1:0];
      got_status = out_tdata[DATA_W+STATUS_W-1:DATA_W];
      got_count  = out_tdata[DATA_W+STATUS_W+COUNT_W-1:DATA_W+STATUS_W];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: entry %h status %0d count %0d",
                   got_entry, got_status, got_count);
      end else begin
        want = pending_results.pop_front();
        if (got_entry !== want.entry || got_status !== want.status ||
            got_count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected entry %h status %0d count %0d, got entry %h status %0d count %0d",
                     want.entry, want.status, want.count, got_entry, got_status, got_count);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel transfers for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    phase_kind_t  plan[12];
    list_result_t no_want;
    pal_op_t      op;

    plan = '{PH_GROW, PH_FILL, PH_MIX, PH_SHRINK, PH_SHRINK, PH_SHRINK,
             PH_GROW, PH_FILL, PH_MIX, PH_SHRINK, PH_SHRINK, PH_MIX};
    no_want.entry  = '0;
    no_want.status = ST_OK;
    no_want.count  = '0;

    // Empty list: every remove and read must report empty, whatever the position.
    add_row(OP_REM_FRONT, 8'd0,   32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 8'd0);
    add_row(OP_READ_AT,   8'd0,   32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 8'd0);
    add_row(OP_REM_BACK,  8'd0,   32'hFFFF_FFFF, 1'b1, 32'h0, ST_EMPTY, 8'd0);
    add_row(OP_REM_AT,    8'd255, 32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 8'd0);
    // insert past the end is out of range, the unused opcode does nothing
    add_row(OP_INS_AT,    8'd1,   32'hDEAD_BEEF, 1'b1, 32'h0, ST_RANGE, 8'd0);
    add_row(OP_NOP,       8'd0,   32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK,    8'd0);
    // build FFFFFFFF, 5A5A5A5A, 00000000, A5A5A5A5
    add_row(OP_INS_FRONT, 8'd0,   32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK,    8'd1);
    add_row(OP_INS_BACK,  8'd0,   32'h0000_0000, 1'b1, 32'h0, ST_OK,    8'd2);
    add_row(OP_INS_AT,    8'd2,   32'hA5A5_A5A5, 1'b1, 32'h0, ST_OK,    8'd3);
    add_row(OP_INS_AT,    8'd1,   32'h5A5A_5A5A, 1'b1, 32'h0, ST_OK,    8'd4);
    add_row(OP_INS_AT,    8'd5,   32'h1234_5678, 1'b1, 32'h0, ST_RANGE, 8'd4);
    add_row(OP_READ_AT,   8'd0,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK, 8'd4);
    add_row(OP_READ_AT,   8'd3,   32'h0000_0000, 1'b0, 32'h0, ST_OK,    8'd0);
    add_row(OP_READ_AT,   8'd4,   32'h0000_0000, 1'b1, 32'h0, ST_RANGE, 8'd4);
    add_row(OP_REM_AT,    8'd255, 32'h0000_0000, 1'b1, 32'h0, ST_RANGE, 8'd4);
    // front insert ignores the position field
    add_row(OP_INS_FRONT, 8'd255, 32'h1234_5678, 1'b0, 32'h0, ST_OK,    8'd0);
    add_row(OP_REM_AT,    8'd2,   32'h0000_0000, 1'b0, 32'h0, ST_OK,    8'd0);
    add_row(OP_REM_BACK,  8'd0,   32'h0000_0000, 1'b0, 32'h0, ST_OK,    8'd0);
    add_row(OP_NOP,       8'd255, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK,    8'd3);
    add_row(OP_REM_FRONT, 8'd0,   32'h0000_0000, 1'b0, 32'h0, ST_OK,    8'd0);
    add_row(OP_REM_AT,    8'd0,   32'h0000_0000, 1'b0, 32'h0, ST_OK,    8'd0);
    add_row(OP_REM_BACK,  8'd0,   32'h0000_0000, 1'b0, 32'h0, ST_OK,    8'd0);
    add_row(OP_REM_FRONT, 8'd0,   32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 8'd0);

    // Hold reset low while the clock runs, then release it at an edge.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_list_op(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].word,
                   dir_rows[i].typed, dir_rows[i].want);

    // Random phases; the third runs with no idling on either side.
    foreach (plan[ph]) begin
      no_idle = (ph == 2);
      repeat (PHASE_ITEMS) begin
        op = pick_op(plan[ph]);
        send_list_op(op, pick_pos(op), $urandom, 1'b0, no_want);
      end
      // drop valid and let the block drain before the next phase
      in_tvalid <= 1'b0;
      wait_drained();
    end
    no_idle = 1'b0;

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/pal_gather.sv
rtl/positional_array_list.sv
rtl/pal_checker.sv
test/tb_top.sv
